>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TDMM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdmm assertion failed");

// Next-cycle implication, off while reset is high.
`define TDMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdmm assertion failed");

`endif

>>> rtl/core/tdmm_pkg.sv
`default_nettype none
package tdmm_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_TRANS = 2'd0,
    ACT_WRITE_STATE = 2'd1,
    ACT_START       = 2'd2,
    ACT_SYMBOL      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_RUNNING    = 3'd0,
    STS_ACCEPTED   = 3'd1,
    STS_EMPTY      = 3'd2,
    STS_BAD_SYMBOL = 3'd3,
    STS_BAD_STATE  = 3'd4,
    STS_UNDEFINED  = 3'd5,
    STS_NOT_FINAL  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_INITIAL_STATE = 2'd0,
    CFG_STATE_COUNT   = 2'd1,
    CFG_SYMBOL_COUNT  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CTRL_READY,
    CTRL_LOOKUP
  } ctrl_state_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [7:0] CHAR_ZERO          = 8'h30;
  localparam logic [5:0] RST_INITIAL_STATE  = 6'd0;
  localparam logic [6:0] RST_STATE_COUNT    = 7'd64;
  localparam logic [4:0] RST_SYMBOL_COUNT   = 5'd16;

  typedef struct packed {
    action_t    action;
    logic [5:0] state_index;
    logic [3:0] symbol_index;
    logic [5:0] next_state;
    logic       next_defined;
    logic [7:0] state_char;
    logic       accepting;
    logic [7:0] symbol_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    status_t    status;
    logic       end_of_string;
  } result_t;

  // table port strobes
  typedef struct packed {
    logic trans_we;
    logic trans_re;
    logic state_we;
    logic state_re;
  } tbl_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/table_driven_moore_machine_top.sv
`default_nettype none
// Channel     Handshake                  Payload
// ----------  -------------------------  -----------------------------
// item in     start & !busy              item    (tdmm_pkg::item_t)
// result out  result_strobe (1 cycle)    result  (tdmm_pkg::result_t)
// config      cfg_we                     cfg_index, cfg_data
//
// Table writes give no result beat. A start's beat shows in the next
// cycle. A symbol is handled as the transition memory read, then a
// busy state that checks the entry and issues the state table read;
// the beat shows in the cycle after that, while the next item is
// already being taken. The transition lookup sets the rate.
// rst is synchronous and clears control state and the accepting flags;
// the tables themselves hold garbage until written. No stall on results.
module table_driven_moore_machine_top #(
  parameter int MAX_STATES  = 64,
  parameter int MAX_SYMBOLS = 16,
  localparam int SW = $clog2(MAX_STATES),
  localparam int TW = $clog2(MAX_STATES * MAX_SYMBOLS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire tdmm_pkg::item_t                     item,
  input  wire logic                                cfg_we,
  input  wire logic [tdmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tdmm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     result_strobe,
  output tdmm_pkg::result_t                        result
);
  import tdmm_pkg::*;

  // limits widened for compares against the fixed 6/8-bit fields
  localparam logic [8:0] MAX_STATES_W  = 9'(MAX_STATES);
  localparam logic [7:0] MAX_SYMBOLS_W = 8'(MAX_SYMBOLS);
  localparam logic [14:0] ROW_STRIDE   = 15'(MAX_SYMBOLS);

  // configuration
  logic [5:0] init_state;
  logic [6:0] state_count;
  logic [4:0] symbol_count;

  // control state
  ctrl_state_t ctrl_state, ctrl_state_next;
  logic [5:0]  cur_state, cur_state_next;
  logic        failed, failed_next;
  logic        lookup_last, lookup_last_next;

  // result stage: char and accepting flag come straight from the state table
  logic    res_valid, res_valid_next;
  status_t res_status, res_status_next;
  logic    res_end, res_end_next;
  logic    res_char_en, res_char_en_next;
  logic    res_acc_check, res_acc_check_next;

  // table interface
  tbl_ctl_t   ctl;
  logic [5:0] trans_row;
  logic [7:0] trans_col;
  logic [14:0] trans_addr_full;
  logic [5:0] state_sel;
  logic [8:0] state_addr_full;
  logic [6:0] trans_rdata;
  logic [7:0] state_rchar;
  logic       state_racc;

  logic       accept;
  logic [7:0] sym;
  logic       sym_ok, cur_ok, init_ok, target_ok, row_ok, col_ok;
  logic       lookup_go;
  logic       entry_defined;
  logic [5:0] entry_target;

  assign accept = start && !busy;
  assign busy   = (ctrl_state == CTRL_LOOKUP);

  // range checks; a zero count puts every symbol or run state out of range (table writes check only the maxima)
  assign sym     = item.symbol_char - CHAR_ZERO;
  assign sym_ok  = (item.symbol_char >= CHAR_ZERO) &&
                   (sym < {3'b0, symbol_count}) && (sym < MAX_SYMBOLS_W);
  assign cur_ok  = ({1'b0, cur_state} < state_count) &&
                   ({3'b0, cur_state} < MAX_STATES_W);
  assign init_ok = ({1'b0, init_state} < state_count) &&
                   ({3'b0, init_state} < MAX_STATES_W);
  assign row_ok  = {3'b0, item.state_index} < MAX_STATES_W;
  assign col_ok  = {4'b0, item.symbol_index} < MAX_SYMBOLS_W;

  assign entry_defined = trans_rdata[6];
  assign entry_target  = trans_rdata[5:0];
  assign target_ok     = ({1'b0, entry_target} < state_count) &&
                         ({3'b0, entry_target} < MAX_STATES_W);

  assign lookup_go = accept && (item.action == ACT_SYMBOL) && !failed && sym_ok && cur_ok;

  // row-major transition address: state * MAX_SYMBOLS + symbol
  assign trans_addr_full = 15'(trans_row) * ROW_STRIDE + 15'(trans_col);
  assign state_addr_full = 9'(state_sel);

  always_comb begin
    ctrl_state_next = ctrl_state;
    case (ctrl_state)
      CTRL_READY: begin
        if (lookup_go) begin
          ctrl_state_next = CTRL_LOOKUP;
        end
      end
      CTRL_LOOKUP: begin
        ctrl_state_next = CTRL_READY;
      end
      default: begin
        ctrl_state_next = CTRL_READY;
      end
    endcase
  end

  always_comb begin
    ctl                = '0;
    trans_row          = item.state_index;
    trans_col          = {4'b0, item.symbol_index};
    state_sel          = item.state_index;
    cur_state_next     = cur_state;
    failed_next        = failed;
    lookup_last_next   = lookup_last;
    res_valid_next     = 1'b0;
    res_status_next    = STS_RUNNING;
    res_end_next       = 1'b0;
    res_char_en_next   = 1'b0;
    res_acc_check_next = 1'b0;
    case (ctrl_state)
      CTRL_READY: begin
        if (accept) begin
          case (item.action)
            ACT_WRITE_TRANS: begin
              ctl.trans_we = row_ok && col_ok;
            end
            ACT_WRITE_STATE: begin
              ctl.state_we = row_ok;
            end
            ACT_START: begin
              cur_state_next = init_state;
              res_valid_next = 1'b1;
              state_sel      = init_state;
              if (!init_ok) begin
                res_status_next = STS_BAD_STATE;
                res_end_next    = 1'b1;
                failed_next     = 1'b1;
              end else begin
                ctl.state_re     = 1'b1;
                res_char_en_next = 1'b1;
                if (item.last) begin
                  res_status_next = STS_EMPTY;
                  res_end_next    = 1'b1;
                  failed_next     = 1'b1;
                end else begin
                  failed_next = 1'b0;
                end
              end
            end
            ACT_SYMBOL: begin
              // dropped silently outside a run
              if (!failed) begin
                if (!sym_ok || !cur_ok) begin
                  res_valid_next  = 1'b1;
                  res_status_next = sym_ok ? STS_BAD_STATE : STS_BAD_SYMBOL;
                  res_end_next    = 1'b1;
                  failed_next     = 1'b1;
                end else begin
                  ctl.trans_re     = 1'b1;
                  trans_row        = cur_state;
                  trans_col        = sym;
                  lookup_last_next = item.last;
                end
              end
            end
            default: ;
          endcase
        end
      end
      CTRL_LOOKUP: begin
        res_valid_next = 1'b1;
        if (!entry_defined || !target_ok) begin
          res_status_next = entry_defined ? STS_BAD_STATE : STS_UNDEFINED;
          res_end_next    = 1'b1;
          failed_next     = 1'b1;
        end else begin
          cur_state_next   = entry_target;
          state_sel        = entry_target;
          ctl.state_re     = 1'b1;
          res_char_en_next = 1'b1;
          if (lookup_last) begin
            res_acc_check_next = 1'b1;
            res_end_next       = 1'b1;
            failed_next        = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state  <= CTRL_READY;
      cur_state   <= '0;
      failed      <= 1'b1;
      lookup_last <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      ctrl_state  <= ctrl_state_next;
      cur_state   <= cur_state_next;
      failed      <= failed_next;
      lookup_last <= lookup_last_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status    <= res_status_next;
    res_end       <= res_end_next;
    res_char_en   <= res_char_en_next;
    res_acc_check <= res_acc_check_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_state   <= RST_INITIAL_STATE;
      state_count  <= RST_STATE_COUNT;
      symbol_count <= RST_SYMBOL_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_STATE: init_state   <= cfg_data[5:0];
        CFG_STATE_COUNT:   state_count  <= cfg_data[6:0];
        CFG_SYMBOL_COUNT:  symbol_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tdmm_tables #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_tables (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .trans_addr  (trans_addr_full[TW-1:0]),
    .trans_wdata ({item.next_defined, item.next_state}),
    .state_addr  (state_addr_full[SW-1:0]),
    .state_wchar (item.state_char),
    .state_wacc  (item.accepting),
    .trans_rdata (trans_rdata),
    .state_rchar (state_rchar),
    .state_racc  (state_racc)
  );

  // result beat: char is zero whenever it is not valid
  assign result_strobe        = res_valid;
  assign result.out_char      = res_char_en ? state_rchar : 8'd0;
  assign result.char_valid    = res_char_en;
  assign result.status        = res_acc_check ? (state_racc ? STS_ACCEPTED : STS_NOT_FINAL)
                                              : res_status;
  assign result.end_of_string = res_end;

endmodule
`default_nettype wire

>>> rtl/core/tdmm_tables.sv
`default_nettype none
module tdmm_tables #(
  parameter int MAX_STATES  = 64,
  parameter int MAX_SYMBOLS = 16,
  localparam int SW = $clog2(MAX_STATES),
  localparam int TW = $clog2(MAX_STATES * MAX_SYMBOLS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tdmm_pkg::tbl_ctl_t ctl,
  input  wire logic [TW-1:0]      trans_addr,
  input  wire logic [6:0]         trans_wdata,
  input  wire logic [SW-1:0]      state_addr,
  input  wire logic [7:0]         state_wchar,
  input  wire logic               state_wacc,
  output logic [6:0]              trans_rdata,
  output logic [7:0]              state_rchar,
  output logic                    state_racc
);
  import tdmm_pkg::*;

  localparam int TDEPTH = MAX_STATES * MAX_SYMBOLS;

  // {defined, next state}
  logic [6:0] trans_mem [TDEPTH];
  // {accepting, char}
  logic [8:0] state_mem [MAX_STATES];
  // accepting flag reads as zero until the row is written
  logic [MAX_STATES-1:0] acc_vld;

  logic [8:0] state_q;
  logic       vld_q;

  always_ff @(posedge clk) begin
    if (ctl.trans_we) begin
      trans_mem[trans_addr] <= trans_wdata;
    end
    if (ctl.trans_re) begin
      trans_rdata <= trans_mem[trans_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.state_we) begin
      state_mem[state_addr] <= {state_wacc, state_wchar};
    end
    if (ctl.state_re) begin
      state_q <= state_mem[state_addr];
      vld_q   <= acc_vld[state_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (ctl.state_we) begin
      acc_vld[state_addr] <= 1'b1;
    end
  end

  assign state_rchar = state_q[7:0];
  assign state_racc  = state_q[8] & vld_q;

endmodule
`default_nettype wire

>>> rtl/core/tdmm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tdmm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_strobe,
  input wire tdmm_pkg::result_t result
);
  import tdmm_pkg::*;

  logic err_beat;
  assign err_beat = result_strobe &&
                    (result.status == STS_BAD_SYMBOL || result.status == STS_BAD_STATE ||
                     result.status == STS_UNDEFINED);

  // lookup is a single cycle
  `TDMM_ASSERT_NEXT(a_busy_one_cycle, clk, rst, busy, !busy)
  // busy only right after a taken item
  `TDMM_ASSERT_NOW(a_busy_after_accept, clk, rst, busy, $past(start && !busy))
  // every beat traces back to a taken item or a lookup
  `TDMM_ASSERT_NOW(a_beat_has_cause, clk, rst, result_strobe,
                   $past(start && !busy) || $past(busy))
  // error beats close the run and carry no char
  `TDMM_ASSERT_NOW(a_error_beat, clk, rst, err_beat,
                   result.end_of_string && !result.char_valid && result.out_char == 8'd0)

endmodule

bind table_driven_moore_machine_top tdmm_checker u_tdmm_checker (.*);
`default_nettype wire

>>> verif/tb_table_driven_moore_machine_top.sv
`timescale 1ns / 1ps

module tb_table_driven_moore_machine_top;
  import tdmm_pkg::*;

  // Index 3 is not a register; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int MAX_PRINTS = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   result_strobe;
  result_t                result;

  table_driven_moore_machine_top u_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .item,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .result_strobe,
    .result
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Machine mirror: tables, run state and register copies.
  // trans_mem entry: bit 6 = transition exists, bits 5..0 = target state.
  // The *_set arrays track which entries were ever loaded, so stimulus
  // never walks into an entry that still holds power-up garbage.
  // ---------------------------------------------------------------------
  logic [6:0] trans_mem [0:1023];
  bit         trans_set [0:1023];
  logic [7:0] char_mem  [0:63];
  bit         char_set  [0:63];
  bit         final_mem [0:63];
  logic [5:0] cur_st;
  bit         halted;
  logic [5:0] cfg_init;
  logic [6:0] cfg_states;
  logic [4:0] cfg_syms;

  result_t predicted_outputs[$];

  int idle_pct;
  int mismatches;
  int beats_sent;
  int live_beats;
  int table_writes;
  int outputs_checked;
  int status_seen [0:7];

  function automatic int states_in_use();
    return (cfg_states < 7'd64) ? int'(cfg_states) : 64;
  endfunction

  function automatic int symbols_in_use();
    return (cfg_syms < 5'd16) ? int'(cfg_syms) : 16;
  endfunction

  // Build one output beat; any beat that ends the string stops the run.
  function automatic result_t pack_output(input logic [7:0] ch, input bit valid,
                                          input status_t st, input bit ends);
    result_t r;
    r = '0;
    r.out_char      = valid ? ch : 8'h00;
    r.char_valid    = valid;
    r.status        = st;
    r.end_of_string = ends;
    if (ends) halted = 1'b1;
    return r;
  endfunction

  // One accepted beat through the mirror. Returns 1 when an output is due.
  function automatic bit moore_step(input item_t it, output result_t r);
    int         n_states;
    int         n_syms;
    int         sym;
    logic [6:0] entry;
    r = '0;
    n_states = states_in_use();
    n_syms   = symbols_in_use();
    case (it.action)
      ACT_WRITE_TRANS: begin
        trans_mem[{it.state_index, it.symbol_index}] = {it.next_defined, it.next_state};
        trans_set[{it.state_index, it.symbol_index}] = 1'b1;
        return 1'b0;
      end
      ACT_WRITE_STATE: begin
        char_mem[it.state_index]  = it.state_char;
        char_set[it.state_index]  = 1'b1;
        final_mem[it.state_index] = it.accepting;
        return 1'b0;
      end
      ACT_START: begin
        halted = 1'b0;
        cur_st = cfg_init;
        if (cur_st >= n_states)
          r = pack_output(8'h00, 1'b0, STS_BAD_STATE, 1'b1);
        else if (it.last)
          r = pack_output(char_mem[cur_st], 1'b1, STS_EMPTY, 1'b1);
        else
          r = pack_output(char_mem[cur_st], 1'b1, STS_RUNNING, 1'b0);
        return 1'b1;
      end
      default: begin
        if (halted) return 1'b0;
        if (it.symbol_char < CHAR_ZERO) begin
          r = pack_output(8'h00, 1'b0, STS_BAD_SYMBOL, 1'b1);
          return 1'b1;
        end
        sym = int'(it.symbol_char - CHAR_ZERO);
        if (sym >= n_syms) begin
          r = pack_output(8'h00, 1'b0, STS_BAD_SYMBOL, 1'b1);
        end else if (cur_st >= n_states) begin
          r = pack_output(8'h00, 1'b0, STS_BAD_STATE, 1'b1);
        end else begin
          entry = trans_mem[{cur_st, sym[3:0]}];
          if (!entry[6]) begin
            r = pack_output(8'h00, 1'b0, STS_UNDEFINED, 1'b1);
          end else if (entry[5:0] >= n_states) begin
            // target out of range: its character is never looked at
            r = pack_output(8'h00, 1'b0, STS_BAD_STATE, 1'b1);
          end else begin
            cur_st = entry[5:0];
            r = pack_output(char_mem[cur_st], 1'b1,
                            it.last ? (final_mem[cur_st] ? STS_ACCEPTED : STS_NOT_FINAL)
                                    : STS_RUNNING,
                            it.last);
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Beat builders. Fields a beat does not use stay random, which keeps
  // every input bit toggling.
  // ---------------------------------------------------------------------
  function automatic item_t rand_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t start_beat(input bit empty);
    item_t it;
    it = rand_beat();
    it.action = ACT_START;
    it.last   = empty;
    return it;
  endfunction

  function automatic item_t sym_beat(input logic [7:0] ch, input bit fin);
    item_t it;
    it = rand_beat();
    it.action      = ACT_SYMBOL;
    it.symbol_char = ch;
    it.last        = fin;
    return it;
  endfunction

  function automatic item_t trans_beat(input logic [5:0] row, input logic [3:0] col,
                                       input logic [5:0] nxt, input bit def);
    item_t it;
    it = rand_beat();
    it.action       = ACT_WRITE_TRANS;
    it.state_index  = row;
    it.symbol_index = col;
    it.next_state   = nxt;
    it.next_defined = def;
    return it;
  endfunction

  function automatic item_t state_beat(input logic [5:0] row, input logic [7:0] ch,
                                       input bit acc);
    item_t it;
    it = rand_beat();
    it.action      = ACT_WRITE_STATE;
    it.state_index = row;
    it.state_char  = ch;
    it.accepting   = acc;
    return it;
  endfunction

  // Mostly stay inside the states in use so strings keep running.
  function automatic logic [5:0] pick_target();
    if ($urandom_range(9) != 0 && states_in_use() > 0)
      return 6'($urandom_range(0, states_in_use() - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------
  // Driving. Start is left high after a beat so back-to-back beats need
  // only one assignment per edge; an idle gap drops it first.
  // ---------------------------------------------------------------------
  task automatic send_beat(input item_t it);
    int      gap;
    bit      due;
    result_t r;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    due = moore_step(it, r);
    if (due) predicted_outputs.insert(predicted_outputs.size(), r);
    beats_sent++;
    if (it.action == ACT_WRITE_TRANS || it.action == ACT_WRITE_STATE) table_writes++;
    if (due || it.action == ACT_WRITE_TRANS || it.action == ACT_WRITE_STATE) live_beats++;
  endtask

  // Load any table entry this beat would read but that was never written.
  task automatic load_missing(input item_t it);
    int         sym;
    int         idx;
    logic [6:0] entry;
    if (it.action == ACT_START) begin
      if (cfg_init < states_in_use() && !char_set[cfg_init])
        send_beat(state_beat(cfg_init, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      return;
    end
    if (it.action != ACT_SYMBOL || halted || it.symbol_char < CHAR_ZERO) return;
    sym = int'(it.symbol_char - CHAR_ZERO);
    if (sym >= symbols_in_use() || cur_st >= states_in_use()) return;
    idx = int'({cur_st, sym[3:0]});
    if (!trans_set[idx])
      send_beat(trans_beat(cur_st, sym[3:0], pick_target(), $urandom_range(0, 9) != 0));
    entry = trans_mem[idx];
    if (entry[6] && entry[5:0] < states_in_use() && !char_set[entry[5:0]])
      send_beat(state_beat(entry[5:0], 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1))));
  endtask

  task automatic send_item(input item_t it);
    load_missing(it);
    send_beat(it);
  endtask

  // Drain outstanding outputs, then wait out any beat that yields
  // nothing but may still be in the lookup pipe.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INITIAL_STATE: cfg_init   = val[5:0];
      CFG_STATE_COUNT:   cfg_states = val;
      CFG_SYMBOL_COUNT:  cfg_syms   = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Output checking: every strobe must match the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe !== 1'b0) begin
      if (predicted_outputs.size() == 0) begin
        flag_mismatch($sformatf("output beat with none due: char %h valid %b status %0d end %b",
                                result.out_char, result.char_valid, result.status,
                                result.end_of_string));
      end else begin
        want = predicted_outputs.pop_front();
        outputs_checked++;
        status_seen[want.status]++;
        if (result.out_char !== want.out_char || result.char_valid !== want.char_valid ||
            result.status !== want.status || result.end_of_string !== want.end_of_string)
          flag_mismatch($sformatf(
            "got char %h valid %b status %0d end %b, want char %h valid %b status %0d end %b",
            result.out_char, result.char_valid, result.status, result.end_of_string,
            want.out_char, want.char_valid, want.status, want.end_of_string));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-built machine: S0 'A' (not final), S1 'B' (final), S63 0xFF (final).
  task automatic test_directed_paths();
    send_item(sym_beat(CHAR_ZERO, 1'b0));            // no run since reset: dropped
    send_item(state_beat(6'd0, 8'h41, 1'b0));
    send_item(state_beat(6'd1, 8'h42, 1'b1));
    send_item(state_beat(6'd63, 8'hFF, 1'b1));
    send_item(trans_beat(6'd0, 4'd0, 6'd1, 1'b1));
    send_item(trans_beat(6'd0, 4'd1, 6'd0, 1'b1));
    send_item(trans_beat(6'd1, 4'd15, 6'd63, 1'b1));
    send_item(trans_beat(6'd63, 4'd0, 6'd5, 1'b0));  // hole in the table
    // 0 -> 1 -> 63 on the highest symbol, then the hole ends the run
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b0));
    send_item(sym_beat(CHAR_ZERO + 8'd15, 1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b1));
    send_item(sym_beat(CHAR_ZERO, 1'b0));            // after an error: dropped
    send_item(start_beat(1'b1));                     // empty string
    send_item(start_beat(1'b0));
    send_item(sym_beat(8'h2F, 1'b0));                // just below '0'
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b1));            // ends in a final state
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO + 8'd1, 1'b1));     // ends in a non-final state
  endtask

  // Range checks driven through the registers.
  task automatic test_count_limits();
    settle();
    write_reg(CFG_STATE_COUNT, 7'd2);
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b0));
    send_item(sym_beat(CHAR_ZERO + 8'd15, 1'b0));    // target 63 out of range
    settle();
    write_reg(CFG_INITIAL_STATE, 7'd63);
    send_item(start_beat(1'b0));                     // initial state out of range
    settle();
    write_reg(CFG_INITIAL_STATE, 7'd0);
    write_reg(CFG_STATE_COUNT, 7'd0);
    send_item(start_beat(1'b0));                     // no states at all
    settle();
    write_reg(CFG_STATE_COUNT, 7'd64);
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b0));
    send_item(sym_beat(CHAR_ZERO + 8'd15, 1'b0));
    settle();
    // run parked in state 63, which now falls outside the states in use
    write_reg(CFG_STATE_COUNT, 7'd2);
    send_item(sym_beat(CHAR_ZERO, 1'b0));
    settle();
    write_reg(CFG_STATE_COUNT, 7'd64);
    write_reg(CFG_SYMBOL_COUNT, 7'd0);
    send_item(start_beat(1'b0));
    send_item(sym_beat(CHAR_ZERO, 1'b0));            // no symbols at all
    settle();
    write_reg(CFG_SPARE_INDEX, 7'h7F);
    write_reg(CFG_SYMBOL_COUNT, 7'd16);
  endtask

  // One string: start, symbols mostly in range, some noise and table
  // rewrites mixed in, sometimes a stray beat afterwards.
  task automatic run_string();
    int         len;
    int         syms;
    logic [7:0] ch;
    item_t      it;
    len = $urandom_range(0, 10);
    send_item(start_beat(len == 0 ? 1'($urandom_range(0, 1)) : 1'b0));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        it = rand_beat();
        it.action = $urandom_range(0, 1) ? ACT_WRITE_STATE : ACT_WRITE_TRANS;
        send_item(it);
      end
      syms = symbols_in_use();
      if ($urandom_range(99) < 88 && syms > 0)
        ch = CHAR_ZERO + 8'($urandom_range(0, syms - 1));
      else
        ch = 8'($urandom_range(0, 255));
      it = sym_beat(ch, i == len - 1);
      if ($urandom_range(49) == 0) it.last = ~it.last;
      send_item(it);
    end
    if ($urandom_range(9) == 0) send_item(rand_beat());
  endtask

  // Four register settings per call: roomy, tiny (long loops), raw random
  // values, and the extremes of each register.
  task automatic test_random_traffic(input int pct, input int beats);
    int goal;
    int n;
    idle_pct = pct;
    for (int k = 0; k < 4; k++) begin
      settle();
      case (k)
        0: begin
          write_reg(CFG_STATE_COUNT, 7'd64);
          write_reg(CFG_SYMBOL_COUNT, 7'd16);
          write_reg(CFG_INITIAL_STATE, 7'($urandom_range(0, 3)));
        end
        1: begin
          n = $urandom_range(1, 4);
          write_reg(CFG_STATE_COUNT, 7'(n));
          write_reg(CFG_SYMBOL_COUNT, 7'($urandom_range(1, 3)));
          write_reg(CFG_INITIAL_STATE, 7'($urandom_range(0, n - 1)));
        end
        2: begin
          write_reg(CFG_STATE_COUNT, 7'($urandom_range(0, 127)));
          write_reg(CFG_SYMBOL_COUNT, 7'($urandom_range(0, 127)));
          write_reg(CFG_INITIAL_STATE, 7'($urandom_range(0, 127)));
        end
        default: begin
          write_reg(CFG_STATE_COUNT, $urandom_range(0, 1) ? 7'd127 : 7'd1);
          write_reg(CFG_SYMBOL_COUNT, $urandom_range(0, 1) ? 7'd31 : 7'd1);
          write_reg(CFG_INITIAL_STATE, $urandom_range(0, 1) ? 7'd63 : 7'd0);
        end
      endcase
      goal = live_beats + beats / 4;
      while (live_beats < goal) run_string();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 64; i++) begin
      char_set[i]  = 1'b0;
      final_mem[i] = 1'b0;
    end
    for (int i = 0; i < 1024; i++) trans_set[i] = 1'b0;
    cur_st     = '0;
    halted     = 1'b1;
    cfg_init   = RST_INITIAL_STATE;
    cfg_states = RST_STATE_COUNT;
    cfg_syms   = RST_SYMBOL_COUNT;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    mismatches      = 0;
    beats_sent      = 0;
    live_beats      = 0;
    table_writes    = 0;
    outputs_checked = 0;
    idle_pct        = 26;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_paths();
    test_count_limits();
    test_random_traffic(26, 268);
    test_random_traffic(60, 266);
    test_random_traffic(0, 266);

    start <= 1'b0;
    for (int w = 0; w < 1000 && predicted_outputs.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_outputs.size() != 0)
      flag_mismatch($sformatf("%0d predicted output beats never arrived",
                              predicted_outputs.size()));

    $display("Run: %0d beats accepted (%0d table loads), %0d output beats compared.",
             beats_sent, table_writes, outputs_checked);
    $display("Outcomes: run %0d, acc %0d, empty %0d, bad sym %0d, bad st %0d, undef %0d, nf %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
